/* rtl/dds_pkg.sv */
// Shared types, register codes and sine table builder for the DDS waveform generator.
// No dependencies; imported by dds_phase, dds_shape and dds_waveform_generator.
`default_nettype none

package dds_pkg;

    localparam int CFG_AW    = 4;
    localparam int DATA_W    = 32;
    localparam int WAVE_W    = 2;
    localparam int AMP_W     = 15;
    localparam int AMP_SHIFT = 15;
    localparam int TRI_SHIFT = 31;
    localparam int M16_W     = 17;
    localparam logic [AMP_W-1:0] AMP_RESET = 15'h7FFF;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2
    } wave_t;

    typedef enum logic [1:0] {
        REG_WAVEFORM     = 2'd0,
        REG_PHASE_STEP   = 2'd1,
        REG_PHASE_OFFSET = 2'd2,
        REG_AMPLITUDE    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [WAVE_W-1:0] waveform;
        logic [31:0]       phase_step;
        logic [31:0]       phase_offset;
        logic [AMP_W-1:0]  amplitude;
    } cfg_t;

    // Q30 sine, degree-13 Taylor in Horner form with truncating steps
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    // Quarter-wave entry k, sampled at the bin center
    function automatic logic [63:0] rom_entry(input int k, input int tb, input int sb);
        logic [63:0] full;
        logic [63:0] x;
        logic [63:0] e;
        full = (64'd1 << (sb - 1)) - 64'd1;
        x    = ((64'(2 * k + 1) * PI_Q30) + (64'd1 << (tb + 1))) >> (tb + 2);
        e    = (sin_q30(x) * full + (64'd1 << 29)) >> 30;
        return (e > full) ? full : e;
    endfunction

endpackage

`default_nettype wire

/* rtl/dds_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] rdata_reg;

    generate
        if (DEPTH > 1) begin : g_multi
            logic [WIDTH-1:0] mem [DEPTH];

            always_ff @(posedge clk)
            begin
                if (we)
                begin
                    mem[waddr] <= wdata;
                end
                rdata_reg <= mem[raddr];
            end
        end else begin : g_single
            logic [WIDTH-1:0] mem;

            always_ff @(posedge clk)
            begin
                if (we && waddr == '0)
                begin
                    mem <= wdata;
                end
                if (raddr == '0)
                begin
                    rdata_reg <= mem;
                end
            end
        end
    endgenerate

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/dds_phase.sv */
// Phase accumulator: RAM-held state, write-to-read forwarding, phase register stage.
// Depends on dds_pkg and dds_ram.
`default_nettype none

module dds_phase
    import dds_pkg::*;
#(
    parameter int PHASE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire logic                  in_valid,
    input  wire logic                  restart,
    output logic                       in_stall,
    output logic                       s1_valid,
    output logic [PHASE_BITS-1:0]      s1_phase,
    input  wire logic                  s2_ready
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [PHASE_BITS-1:0] s1_phase_reg;
    logic                  fwd_valid_reg;
    logic [PHASE_BITS-1:0] fwd_data_reg;
    logic                  acc_written_reg;
    logic [PHASE_BITS-1:0] ram_rdata;
    logic [PHASE_BITS-1:0] acc_q;
    logic [PHASE_BITS-1:0] acc_cur;
    logic [PHASE_BITS-1:0] acc_next;
    logic [PHASE_BITS-1:0] step_ext;
    logic [PHASE_BITS-1:0] offset_ext;
    logic                  rdy1;
    logic                  accept;

    assign step_ext   = PHASE_BITS'(cfg.phase_step);
    assign offset_ext = PHASE_BITS'(cfg.phase_offset);

    assign rdy1     = !s1_valid_reg || s2_ready;
    assign accept   = in_valid && rdy1;
    assign in_stall = !rdy1;

    dds_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (1)
    ) u_acc_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (1'b0),
        .wdata (acc_next),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    // last write is not yet visible at the registered RAM output, so it is forwarded
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            acc_q = fwd_data_reg;
        end else if (acc_written_reg)
        begin
            acc_q = ram_rdata;
        end else
        begin
            acc_q = '0;
        end
        acc_cur  = restart ? '0 : acc_q;
        acc_next = acc_cur + step_ext;
    end

    assign s1_valid_next = rdy1 ? in_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            acc_written_reg <= 1'b0;
        end else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= accept;
            if (accept)
            begin
                acc_written_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= acc_next;
            s1_phase_reg <= acc_cur + offset_ext;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_phase = s1_phase_reg;

    a_restart_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> (fwd_data_reg == $past(step_ext)))
        else $error("restart beat did not store phase_step");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (fwd_valid_reg && acc_written_reg))
        else $error("accumulator write not forwarded");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && !s2_ready))
        else $error("input stalled with free phase stage");

endmodule

`default_nettype wire

/* rtl/dds_shape.sv */
// Waveform shaping pipeline: table/square/triangle base, amplitude multiply, round, clamp, sign.
// Depends on dds_pkg.
`default_nettype none

module dds_shape
    import dds_pkg::*;
#(
    parameter int PHASE_BITS  = 32,
    parameter int TABLE_BITS  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cfg_t                          cfg,
    input  wire logic                          s1_valid,
    input  wire logic [PHASE_BITS-1:0]         s1_phase,
    output logic                               s2_ready,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      sample
);

    localparam int FW     = SAMPLE_BITS - 1;
    localparam int TSIZE  = 1 << TABLE_BITS;
    localparam int BASE_W = M16_W + FW;
    localparam int PROD_W = BASE_W + AMP_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int QW     = PHASE_BITS - 2;
    localparam int LSH    = (QW < 16) ? (16 - QW) : 0;
    localparam int RSH    = (QW >= 16) ? (QW - 16) : 0;
    localparam int TRI_W  = PHASE_BITS - 1 + LSH;
    localparam logic [FW-1:0] FULL = '1;

    logic [FW-1:0] rom [TSIZE];

    genvar k;
    generate
        for (k = 0; k < TSIZE; k++) begin : g_rom
            assign rom[k] = FW'(rom_entry(k, TABLE_BITS, SAMPLE_BITS));
        end
    endgenerate

    logic                   v2_reg;
    logic                   v3_reg;
    logic                   out_valid_reg;
    logic                   rdy2;
    logic                   rdy3;
    logic                   rdy_out;
    logic [1:0]             quad;
    logic [TABLE_BITS-1:0]  idx;
    logic [QW-1:0]          rem;
    logic [PHASE_BITS-2:0]  tri_m;
    logic [M16_W-1:0]       m16;
    logic [BASE_W-1:0]      base_next;
    logic [BASE_W-1:0]      base_reg;
    logic                   neg2_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   neg3_reg;
    logic [RND_W-1:0]       rnd;
    logic [FW-1:0]          mag;
    logic [SAMPLE_BITS-1:0] sample_next;
    logic [SAMPLE_BITS-1:0] sample_reg;

    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign s2_ready = rdy2;

    // stage 2: quadrant decode and base value
    always_comb
    begin
        quad = s1_phase[PHASE_BITS-1 -: 2];
        rem  = s1_phase[QW-1:0];
        idx  = s1_phase[QW-1 -: TABLE_BITS];
        if (quad[0])
        begin
            idx = ~idx;
        end
        if (quad[0])
        begin
            tri_m = {1'b1, {QW{1'b0}}} - {1'b0, rem};
        end else
        begin
            tri_m = {1'b0, rem};
        end
        m16 = M16_W'((TRI_W'(tri_m) << LSH) >> RSH);
        case (cfg.waveform)
            WAVE_SINE:     base_next = BASE_W'(rom[idx]);
            WAVE_SQUARE:   base_next = BASE_W'(FULL);
            WAVE_TRIANGLE: base_next = BASE_W'(m16) * BASE_W'(FULL);
            default:       base_next = '0;
        endcase
    end

    // stage 4: round, clamp, apply sign
    always_comb
    begin
        if (cfg.waveform == WAVE_TRIANGLE)
        begin
            rnd = ({1'b0, prod_reg} + (RND_W'(1) << (TRI_SHIFT - 1))) >> TRI_SHIFT;
        end else
        begin
            rnd = ({1'b0, prod_reg} + (RND_W'(1) << (AMP_SHIFT - 1))) >> AMP_SHIFT;
        end
        mag = (rnd > RND_W'(FULL)) ? FULL : rnd[FW-1:0];
        if (neg3_reg)
        begin
            sample_next = SAMPLE_BITS'(0) - {1'b0, mag};
        end else
        begin
            sample_next = {1'b0, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else
        begin
            if (rdy2)
            begin
                v2_reg <= s1_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid)
        begin
            base_reg <= base_next;
            neg2_reg <= quad[1];
        end
        if (rdy3 && v2_reg)
        begin
            prod_reg <= PROD_W'(base_reg) * PROD_W'(cfg.amplitude);
            neg3_reg <= neg2_reg;
        end
        if (rdy_out && v3_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    a_sample_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg != {1'b1, {FW{1'b0}}}))
        else $error("sample outside symmetric range");

endmodule

`default_nettype wire

/* rtl/dds_waveform_generator.sv */
// DDS waveform generator top: an accepted tick beat passes the phase, base, product and
// sample registers to a sample beat. Throughput one beat per clock unless the output stalls;
// the accumulator RAM is read-modify-written every beat with forwarding, and three shaping
// stages follow the phase stage. Output stall backs up stage by stage; bubbles are absorbed
// before the input stalls. Reset (rst_n low, async) empties the pipeline, zeroes the
// accumulator and loads register defaults: sine, zero step and offset, amplitude 32767.
`default_nettype none

module dds_waveform_generator
    import dds_pkg::*;
#(
    parameter int PHASE_BITS  = 32,
    parameter int TABLE_BITS  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [CFG_AW-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic      [DATA_W-1:0]         prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      restart,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [SAMPLE_BITS-1:0]  sample
);

    cfg_t                  cfg_reg;
    logic                  cfg_we;
    reg_idx_t              reg_idx;
    logic                  s1_valid;
    logic [PHASE_BITS-1:0] s1_phase;
    logic                  s2_ready;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.waveform     <= WAVE_SINE;
            cfg_reg.phase_step   <= '0;
            cfg_reg.phase_offset <= '0;
            cfg_reg.amplitude    <= AMP_RESET;
        end else if (cfg_we)
        begin
            case (reg_idx)
                REG_WAVEFORM:     cfg_reg.waveform     <= pwdata[WAVE_W-1:0];
                REG_PHASE_STEP:   cfg_reg.phase_step   <= pwdata;
                REG_PHASE_OFFSET: cfg_reg.phase_offset <= pwdata;
                REG_AMPLITUDE:    cfg_reg.amplitude    <= pwdata[AMP_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WAVEFORM:     prdata = DATA_W'(cfg_reg.waveform);
            REG_PHASE_STEP:   prdata = cfg_reg.phase_step;
            REG_PHASE_OFFSET: prdata = cfg_reg.phase_offset;
            REG_AMPLITUDE:    prdata = DATA_W'(cfg_reg.amplitude);
            default:          prdata = '0;
        endcase
    end

    dds_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .restart  (restart),
        .in_stall (in_stall),
        .s1_valid (s1_valid),
        .s1_phase (s1_phase),
        .s2_ready (s2_ready)
    );

    dds_shape #(
        .PHASE_BITS  (PHASE_BITS),
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s1_valid  (s1_valid),
        .s1_phase  (s1_phase),
        .s2_ready  (s2_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

endmodule

`default_nettype wire

/* tb/dds_waveform_generator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dds_waveform_generator: APB register setup, tick beats in,
// sample beats out, checked against an in-bench DDS predictor or a given level. Needs dds_pkg and the RTL.

module dds_waveform_generator_tb;
    import dds_pkg::*;

    localparam int          N_DIRECTED = 31;
    localparam int          N_PHASES   = 15;
    localparam int          PHASE_LEN  = 50;
    localparam int          CYCLE_CAP  = 500000;
    localparam logic [63:0] FULL_SCALE = 64'd32767;
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] Q30_PI     = 64'd3373259426;

    typedef enum logic { ROW_WRITE, ROW_TICK } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    ridx;
        logic [31:0] value;
        logic        clr;
        logic        typed;
        logic [15:0] level;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_AW-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic                    restart;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [15:0]      sample;

    // predictor state
    logic [15:0]             quarter_sine [256];
    logic [31:0]             acc;
    logic [1:0]              cur_wave;
    logic [31:0]             cur_step;
    logic [31:0]             cur_offset;
    logic [14:0]             cur_amp;

    logic signed [15:0]      sample_q [$];
    int                      fail_count = 0;
    int                      out_count = 0;
    int                      cycle_count = 0;
    bit                      calm = 1'b0;

    logic                    in_fire_n = 1'b0;
    logic                    out_fire_n = 1'b0;
    logic signed [15:0]      out_sample_n;

    stim_row_t plan [N_DIRECTED] = '{
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b1, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_WAVEFORM,     32'(WAVE_SQUARE), 1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b1, 16'd32766},
        '{ROW_WRITE, REG_PHASE_OFFSET, 32'h8000_0000,   1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b1, 1'b1, -16'sd32766},
        '{ROW_WRITE, REG_WAVEFORM,     32'(WAVE_TRIANGLE), 1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b1, 16'd0},
        '{ROW_WRITE, REG_PHASE_OFFSET, 32'h4000_0000,   1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b1, 16'd32766},
        '{ROW_WRITE, REG_PHASE_OFFSET, 32'hC000_0000,   1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b1, -16'sd32766},
        '{ROW_WRITE, REG_PHASE_STEP,   32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b1, 1'b0, 16'd0},
        '{ROW_WRITE, REG_AMPLITUDE,    32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b1, 16'd0},
        '{ROW_WRITE, REG_AMPLITUDE,    32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_WAVEFORM,     32'hFFFF_FFFF,   1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b1, 16'd0},
        '{ROW_WRITE, REG_WAVEFORM,     32'(WAVE_SINE),  1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_PHASE_OFFSET, 32'h3FFF_FFFF,   1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_PHASE_STEP,   32'h4000_0000,   1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b1, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0},
        '{ROW_WRITE, REG_AMPLITUDE,    32'd1,           1'b0, 1'b0, 16'd0},
        '{ROW_TICK,  REG_WAVEFORM,     32'd0,           1'b0, 1'b0, 16'd0}
    };

    dds_waveform_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    always #5 clk = ~clk;

    // Taylor sine in Q30, Horner form, truncating at every step
    function automatic logic [63:0] taylor_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int n = 12; n >= 2; n -= 2)
        begin
            t = Q30_ONE - ((x2 * t) >> 30) / 64'(n * (n + 1));
        end
        return (x * t) >> 30;
    endfunction

    function automatic logic [15:0] next_sample(input logic clr);
        logic [31:0] ph;
        logic [29:0] r;
        logic [7:0]  idx;
        logic [30:0] m;
        logic [63:0] mag;
        if (clr)
        begin
            acc = 32'd0;
        end
        ph  = acc + cur_offset;
        r   = ph[29:0];
        mag = 64'd0;
        case (cur_wave)
            WAVE_SINE:
            begin
                idx = r[29:22];
                if (ph[30])
                begin
                    idx = ~idx;
                end
                mag = (64'(quarter_sine[idx]) * 64'(cur_amp) + (64'd1 << 14)) >> 15;
            end
            WAVE_SQUARE:
            begin
                mag = (FULL_SCALE * 64'(cur_amp) + (64'd1 << 14)) >> 15;
            end
            WAVE_TRIANGLE:
            begin
                m   = ph[30] ? (31'h4000_0000 - {1'b0, r}) : {1'b0, r};
                mag = ((64'(m) >> 14) * FULL_SCALE * 64'(cur_amp) + (64'd1 << 30)) >> 31;
            end
            default:
            begin
                mag = 64'd0;
            end
        endcase
        if (mag > FULL_SCALE)
        begin
            mag = FULL_SCALE;
        end
        acc = acc + cur_step;
        return ph[31] ? (16'd0 - mag[15:0]) : mag[15:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(input logic signed [15:0] want, input logic signed [15:0] got);
        $display("ERROR beat %0d: sample %0d, expected %0d", out_count, got, want);
        fail_count++;
    endtask

    task automatic send_tick(input logic clr, input logic typed, input logic [15:0] level);
        int          gap;
        logic [15:0] predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= clr;
        do @(posedge clk); while (!in_fire_n);
        predicted = next_sample(clr);
        sample_q.push_back(typed ? level : predicted);
    endtask

    // block must be idle before a register write
    task automatic settle();
        in_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t ridx, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (ridx)
            REG_WAVEFORM:     cur_wave   = value[1:0];
            REG_PHASE_STEP:   cur_step   = value;
            REG_PHASE_OFFSET: cur_offset = value;
            REG_AMPLITUDE:    cur_amp    = value[14:0];
            default:          ;
        endcase
    endtask

    always @(negedge clk)
    begin
        in_fire_n    = rst_n && in_valid && !in_stall;
        out_fire_n   = rst_n && out_valid && !out_stall;
        out_sample_n = sample;
    end

    always @(posedge clk)
    begin
        if (out_fire_n)
        begin
            if (sample_q.size() == 0)
            begin
                $display("ERROR beat %0d: sample %0d with nothing expected", out_count,
                         out_sample_n);
                fail_count++;
            end
            else if (out_sample_n !== sample_q[0])
            begin
                report_mismatch(sample_q.pop_front(), out_sample_n);
            end
            else
            begin
                void'(sample_q.pop_front());
            end
            out_count++;
        end
    end

    // output backpressure: short bursts, occasional long stalls and long open stretches
    initial
    begin
        int r;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            r = $urandom_range(0, 99);
            repeat (r < 50 ? $urandom_range(1, 3) :
                    r < 85 ? $urandom_range(4, 12) : $urandom_range(40, 200)) @(posedge clk);
            out_stall <= 1'b1;
            r = $urandom_range(0, 99);
            repeat (r < 70 ? $urandom_range(1, 2) :
                    r < 95 ? $urandom_range(3, 8) : $urandom_range(20, 40)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("dds_waveform_generator test failed");
        $finish;
    end

    initial
    begin
        int r;
        for (int k = 0; k < 256; k++)
        begin
            logic [63:0] x;
            logic [63:0] e;
            x = (64'(2 * k + 1) * Q30_PI + 64'd512) >> 10;
            e = (taylor_sin(x) * FULL_SCALE + (64'd1 << 29)) >> 30;
            quarter_sine[k] = (e > FULL_SCALE) ? FULL_SCALE[15:0] : e[15:0];
        end
        acc        = 32'd0;
        cur_wave   = WAVE_SINE;
        cur_step   = 32'd0;
        cur_offset = 32'd0;
        cur_amp    = AMP_RESET;

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        restart  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                apb_write(plan[i].ridx, plan[i].value);
            end
            else
            begin
                send_tick(plan[i].clr, plan[i].typed, plan[i].level);
            end
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            calm = (p % 5 == 2);
            r = $urandom_range(0, 7);
            apb_write(REG_WAVEFORM, r == 0 ? $urandom : 32'($urandom_range(0, 3)));
            case ($urandom_range(0, 4))
                0:       apb_write(REG_PHASE_STEP, $urandom_range(0, 4096));
                1:       apb_write(REG_PHASE_STEP, 32'hFFFF_FFFF - $urandom_range(0, 4096));
                2:       apb_write(REG_PHASE_STEP, 32'd1 << $urandom_range(0, 31));
                default: apb_write(REG_PHASE_STEP, $urandom);
            endcase
            apb_write(REG_PHASE_OFFSET, r == 1 ? 32'd0 : $urandom);
            case ($urandom_range(0, 3))
                0:       apb_write(REG_AMPLITUDE, 32'd32767);
                1:       apb_write(REG_AMPLITUDE, $urandom_range(0, 32767));
                2:       apb_write(REG_AMPLITUDE, $urandom);
                default: apb_write(REG_AMPLITUDE, $urandom_range(0, 3));
            endcase
            for (int j = 0; j < PHASE_LEN; j++)
            begin
                send_tick(j == 0 || $urandom_range(0, 15) == 0, 1'b0, 16'd0);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sample_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("dds_waveform_generator test passed");
        end
        else
        begin
            $display("dds_waveform_generator test failed");
        end
        $finish;
    end

endmodule
